@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types, constants and index helpers for the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

   // region geometry
   localparam int REGION_LOG2 = 16;
   localparam int LEAF_LOG2   = 4;
   localparam int LEVELS      = REGION_LOG2 - LEAF_LOG2 + 1;
   localparam int IDX_W       = REGION_LOG2 - LEAF_LOG2;
   localparam int LEAVES      = 1 << IDX_W;
   localparam int LINK_W      = IDX_W + 1;
   localparam int LVL_W       = $clog2(LEVELS);
   localparam int BYTES_W     = REGION_LOG2 + 1;

   // item field widths
   localparam int REQ_W = 17;
   localparam int OFF_W = 16;
   localparam int SZL_W = $clog2(REQ_W + 1);

   // end-of-list marker
   localparam logic [LINK_W-1:0] NIL = LINK_W'(LEAVES);

   // metadata block reserved after reset
   localparam int META_REQ_LOG2 = LEVELS - 3;
   localparam int META_LOG2     = (META_REQ_LOG2 > LEAF_LOG2) ? META_REQ_LOG2 : LEAF_LOG2;
   localparam int META_LVL      = REGION_LOG2 - META_LOG2;
   localparam int META_BYTES    = 1 << META_LOG2;
   localparam int META_PAR_LIM  = (META_LVL == 0) ? 0 : (1 << (META_LVL - 1));
   localparam int META_SPAN     = 1 << (IDX_W - META_LVL);

   // item kinds
   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   // result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FAIL = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [REQ_W-1:0]  request_bytes;
      logic [OFF_W-1:0]  block_offset;
   } req_type;

   typedef struct packed {
      logic              status;
      logic [OFF_W-1:0]  granted_offset;
   } rsp_type;

   // list links of one leaf
   typedef struct packed {
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
   } link_type;

   // split mark and pair parity of one tree node
   typedef struct packed {
      logic split;
      logic parity;
   } bits_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      link_type         wdata;
   } link_cmd_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] addr;
      bits_type         wdata;
   } bit_cmd_type;

   // block span in leaves at a level
   function automatic logic [IDX_W:0] span_of(input logic [LVL_W-1:0] lvl);
      return {{IDX_W{1'b0}}, 1'b1} << (LVL_W'(IDX_W) - lvl);
   endfunction

   // node index shared by the pair parity at level k and the split mark of the parent
   function automatic logic [IDX_W-1:0] bit_idx(input logic [IDX_W-1:0] x,
                                                input logic [LVL_W-1:0] k);
      logic [IDX_W:0] base;
      logic [IDX_W:0] sh;
      logic [IDX_W:0] sum;
      base = ({{IDX_W{1'b0}}, 1'b1} << (k - 1'b1)) - 1'b1;
      sh   = {1'b0, x} >> (LVL_W'(IDX_W + 1) - k);
      sum  = base + sh;
      return sum[IDX_W-1:0];
   endfunction

   // node bits set by the metadata allocation
   function automatic logic meta_bit(input logic [IDX_W-1:0] i);
      logic [IDX_W:0] w;
      w = {1'b0, i};
      return ((w & (w + 1'b1)) == '0) && (w < (IDX_W + 1)'(META_PAR_LIM));
   endfunction

   // right halves pushed by the metadata allocation
   function automatic logic meta_link(input logic [IDX_W-1:0] i);
      logic [IDX_W:0] w;
      w = {1'b0, i};
      return (w != '0) && ((w & (w - 1'b1)) == '0) && (w >= (IDX_W + 1)'(META_SPAN));
   endfunction

   // free-list heads after reset
   function automatic logic [LINK_W-1:0] head_reset(input logic [LVL_W-1:0] lvl);
      logic [LINK_W-1:0] h;
      h = NIL;
      if ((lvl != '0) && (lvl <= LVL_W'(META_LVL))) begin
         h = span_of(lvl);
      end
      return h;
   endfunction

endpackage

@@ rtl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-port RAM, registered read that returns the old contents on a write.
// ----------------------------------------------------------------------------
module bba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // array write and registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, level search, split and merge walks over the
// link and node-bit memories, free-list heads and byte budget.
// ----------------------------------------------------------------------------
module bba_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  bba_pkg::req_type      req_item,
   input  logic                  slot_free,
   output logic                  idle,
   output logic                  done,
   output bba_pkg::rsp_type      result,
   output bba_pkg::link_cmd_type link_cmd,
   input  bba_pkg::link_type     link_rd,
   output bba_pkg::bit_cmd_type  bit_cmd,
   input  bba_pkg::bits_type     bit_rd
);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_A_SIZE, S_A_SRCH, S_A_POP, S_A_NXT_WR, S_A_PAR_RD, S_A_PAR_WR,
      S_A_SPL_RD, S_A_SPL_WR, S_A_FIN,
      S_F_SRCH_RD, S_F_SRCH_CK, S_F_ALIGN, S_F_MRG_RD, S_F_MRG_CK,
      S_U_RD, S_U_CK, S_U_P_WR, S_U_N_RD, S_U_N_WR,
      S_P_START, S_P_H_WR, S_P_X,
      S_DONE
   } state_type;

   state_type                         state_ff, state_in;
   logic [bba_pkg::REQ_W-1:0]         req_ff, req_in;
   logic [bba_pkg::IDX_W-1:0]         x_ff, x_in;
   logic [bba_pkg::IDX_W-1:0]         b_ff, b_in;
   logic [bba_pkg::IDX_W-1:0]         gnt_ff, gnt_in;
   logic [bba_pkg::IDX_W-1:0]         clr_ff, clr_in;
   logic [bba_pkg::LVL_W-1:0]         lvl_ff, lvl_in;
   logic [bba_pkg::LVL_W-1:0]         j_ff, j_in;
   logic [bba_pkg::BYTES_W-1:0]       size_ff, size_in;
   logic [bba_pkg::BYTES_W-1:0]       bytes_ff, bytes_in;
   logic [bba_pkg::LINK_W-1:0]        n_ff, n_in;
   logic [bba_pkg::LINK_W-1:0]        p_ff, p_in;
   logic                              fail_ff, fail_in;
   logic [bba_pkg::LINK_W-1:0]        heads_ff [bba_pkg::LEVELS];

   logic                              head_we;
   logic [bba_pkg::LVL_W-1:0]         head_widx;
   logic [bba_pkg::LINK_W-1:0]        head_wdata;
   logic [bba_pkg::LVL_W-1:0]         head_ridx;
   logic [bba_pkg::LINK_W-1:0]        head_rd;

   logic [bba_pkg::REQ_W-1:0]         reqc;
   logic [bba_pkg::REQ_W-1:0]         rm1;
   logic [bba_pkg::SZL_W-1:0]         c_log2;
   logic [bba_pkg::BYTES_W-1:0]       a_size;
   logic [bba_pkg::BYTES_W:0]         a_total;
   logic                              a_fail;
   logic [bba_pkg::BYTES_W-1:0]       f_size;
   logic [bba_pkg::IDX_W:0]           sp;
   logic [bba_pkg::IDX_W:0]           right;
   logic [bba_pkg::IDX_W-1:0]         nd_idx;

   // request rounded up to a power of two
   always_comb begin
      reqc = (req_ff < bba_pkg::REQ_W'(1 << bba_pkg::LEAF_LOG2)) ?
             bba_pkg::REQ_W'(1 << bba_pkg::LEAF_LOG2) : req_ff;
      rm1  = reqc - 1'b1;
      c_log2 = '0;
      for (int i = 0; i < bba_pkg::REQ_W; i++) begin
         if (rm1[i]) begin
            c_log2 = bba_pkg::SZL_W'(i + 1);
         end
      end
      a_size  = {{(bba_pkg::BYTES_W-1){1'b0}}, 1'b1} << c_log2;
      a_total = {1'b0, a_size} + {1'b0, bytes_ff};
      a_fail  = (c_log2 > bba_pkg::SZL_W'(bba_pkg::REGION_LOG2)) ||
                (a_total > (bba_pkg::BYTES_W + 1)'(1 << bba_pkg::REGION_LOG2));
   end

   // level helpers
   assign f_size    = {{(bba_pkg::BYTES_W-1){1'b0}}, 1'b1} <<
                      (bba_pkg::SZL_W'(bba_pkg::REGION_LOG2) - bba_pkg::SZL_W'(lvl_ff));
   assign sp        = bba_pkg::span_of(lvl_ff);
   assign right     = {1'b0, x_ff} + bba_pkg::span_of(j_ff);
   assign head_ridx = (state_ff == S_P_START) ? lvl_ff : j_ff;
   assign head_rd   = heads_ff[head_ridx];

   // next state and memory commands
   always_comb begin
      state_in   = state_ff;
      req_in     = req_ff;
      x_in       = x_ff;
      b_in       = b_ff;
      gnt_in     = gnt_ff;
      clr_in     = clr_ff;
      lvl_in     = lvl_ff;
      j_in       = j_ff;
      size_in    = size_ff;
      bytes_in   = bytes_ff;
      n_in       = n_ff;
      p_in       = p_ff;
      fail_in    = fail_ff;
      head_we    = 1'b0;
      head_widx  = j_ff;
      head_wdata = bba_pkg::NIL;
      nd_idx     = '0;
      link_cmd   = '{we: 1'b0, addr: x_ff, wdata: '{next: bba_pkg::NIL, prev: bba_pkg::NIL}};
      bit_cmd    = '{we: 1'b0, addr: '0, wdata: '{split: 1'b0, parity: 1'b0}};
      done       = 1'b0;

      unique case (state_ff)
         // sweep the node bits and seed the metadata split
         S_CLEAR: begin
            bit_cmd.we           = 1'b1;
            bit_cmd.addr         = clr_ff;
            bit_cmd.wdata.split  = bba_pkg::meta_bit(clr_ff);
            bit_cmd.wdata.parity = bba_pkg::meta_bit(clr_ff);
            link_cmd.we          = bba_pkg::meta_link(clr_ff);
            link_cmd.addr        = clr_ff;
            clr_in               = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               req_in = req_item.request_bytes;
               x_in   = bba_pkg::IDX_W'(req_item.block_offset >> bba_pkg::LEAF_LOG2);
               if (req_item.kind == bba_pkg::KIND_ALLOC) begin
                  state_in = S_A_SIZE;
               end else begin
                  j_in     = bba_pkg::LVL_W'(bba_pkg::LEVELS - 1);
                  state_in = S_F_SRCH_RD;
               end
            end
         end

         // size class and budget check
         S_A_SIZE: begin
            if (a_fail) begin
               fail_in  = 1'b1;
               gnt_in   = '0;
               state_in = S_DONE;
            end else begin
               lvl_in   = bba_pkg::LVL_W'(bba_pkg::SZL_W'(bba_pkg::REGION_LOG2) - c_log2);
               j_in     = bba_pkg::LVL_W'(bba_pkg::SZL_W'(bba_pkg::REGION_LOG2) - c_log2);
               size_in  = a_size;
               state_in = S_A_SRCH;
            end
         end

         // nearest non-empty level at or above the target
         S_A_SRCH: begin
            if (head_rd != bba_pkg::NIL) begin
               x_in          = head_rd[bba_pkg::IDX_W-1:0];
               link_cmd.addr = head_rd[bba_pkg::IDX_W-1:0];
               state_in      = S_A_POP;
            end else if (j_ff == '0) begin
               fail_in  = 1'b1;
               gnt_in   = '0;
               state_in = S_DONE;
            end else begin
               j_in = j_ff - 1'b1;
            end
         end

         // pop the head
         S_A_POP: begin
            head_we    = 1'b1;
            head_widx  = j_ff;
            head_wdata = link_rd.next;
            n_in       = link_rd.next;
            if (link_rd.next != bba_pkg::NIL) begin
               link_cmd.addr = link_rd.next[bba_pkg::IDX_W-1:0];
               state_in      = S_A_NXT_WR;
            end else begin
               state_in = S_A_PAR_RD;
            end
         end

         S_A_NXT_WR: begin
            link_cmd.we         = 1'b1;
            link_cmd.addr       = n_ff[bba_pkg::IDX_W-1:0];
            link_cmd.wdata.next = link_rd.next;
            link_cmd.wdata.prev = bba_pkg::NIL;
            state_in            = S_A_PAR_RD;
         end

         // toggle the parity of the popped block's pair
         S_A_PAR_RD: begin
            if (j_ff != '0) begin
               bit_cmd.addr = bba_pkg::bit_idx(x_ff, j_ff);
               state_in     = S_A_PAR_WR;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = (j_ff < lvl_ff) ? S_A_SPL_RD : S_A_FIN;
            end
         end

         S_A_PAR_WR: begin
            bit_cmd.we           = 1'b1;
            bit_cmd.addr         = bba_pkg::bit_idx(x_ff, j_ff);
            bit_cmd.wdata.split  = bit_rd.split;
            bit_cmd.wdata.parity = ~bit_rd.parity;
            j_in                 = j_ff + 1'b1;
            state_in             = (j_ff < lvl_ff) ? S_A_SPL_RD : S_A_FIN;
         end

         // split one level: right half becomes the level's only free block
         S_A_SPL_RD: begin
            head_we       = 1'b1;
            head_widx     = j_ff;
            head_wdata    = {1'b0, right[bba_pkg::IDX_W-1:0]};
            link_cmd.we   = 1'b1;
            link_cmd.addr = right[bba_pkg::IDX_W-1:0];
            bit_cmd.addr  = bba_pkg::bit_idx(x_ff, j_ff);
            state_in      = S_A_SPL_WR;
         end

         S_A_SPL_WR: begin
            bit_cmd.we           = 1'b1;
            bit_cmd.addr         = bba_pkg::bit_idx(x_ff, j_ff);
            bit_cmd.wdata.split  = 1'b1;
            bit_cmd.wdata.parity = ~bit_rd.parity;
            if (j_ff == lvl_ff) begin
               state_in = S_A_FIN;
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = S_A_SPL_RD;
            end
         end

         S_A_FIN: begin
            bytes_in = bytes_ff + size_ff;
            gnt_in   = x_ff;
            fail_in  = 1'b0;
            state_in = S_DONE;
         end

         // level of the freed block from the deepest split parent
         S_F_SRCH_RD: begin
            bit_cmd.addr = bba_pkg::bit_idx(x_ff, j_ff);
            state_in     = S_F_SRCH_CK;
         end

         S_F_SRCH_CK: begin
            if (bit_rd.split) begin
               lvl_in   = j_ff;
               state_in = S_F_ALIGN;
            end else if (j_ff == bba_pkg::LVL_W'(1)) begin
               lvl_in   = '0;
               state_in = S_F_ALIGN;
            end else begin
               j_in     = j_ff - 1'b1;
               state_in = S_F_SRCH_RD;
            end
         end

         // align and release the budget, saturating at zero
         S_F_ALIGN: begin
            nd_idx   = bba_pkg::IDX_W'(sp - 1'b1);
            x_in     = x_ff & ~nd_idx;
            bytes_in = (bytes_ff >= f_size) ? (bytes_ff - f_size) : '0;
            state_in = S_F_MRG_RD;
         end

         // merge walk
         S_F_MRG_RD: begin
            if (lvl_ff == '0) begin
               state_in = S_P_START;
            end else begin
               bit_cmd.addr = bba_pkg::bit_idx(x_ff, lvl_ff);
               state_in     = S_F_MRG_CK;
            end
         end

         S_F_MRG_CK: begin
            bit_cmd.we   = 1'b1;
            bit_cmd.addr = bba_pkg::bit_idx(x_ff, lvl_ff);
            if (!bit_rd.parity) begin
               bit_cmd.wdata.split  = bit_rd.split;
               bit_cmd.wdata.parity = 1'b1;
               state_in             = S_P_START;
            end else begin
               b_in     = x_ff ^ sp[bba_pkg::IDX_W-1:0];
               state_in = S_U_RD;
            end
         end

         // unlink the buddy from its level list
         S_U_RD: begin
            link_cmd.addr = b_ff;
            state_in      = S_U_CK;
         end

         S_U_CK: begin
            p_in = link_rd.prev;
            n_in = link_rd.next;
            if (link_rd.prev != bba_pkg::NIL) begin
               link_cmd.addr = link_rd.prev[bba_pkg::IDX_W-1:0];
               state_in      = S_U_P_WR;
            end else begin
               head_we    = 1'b1;
               head_widx  = lvl_ff;
               head_wdata = link_rd.next;
               state_in   = S_U_N_RD;
            end
         end

         S_U_P_WR: begin
            link_cmd.we         = 1'b1;
            link_cmd.addr       = p_ff[bba_pkg::IDX_W-1:0];
            link_cmd.wdata.next = n_ff;
            link_cmd.wdata.prev = link_rd.prev;
            state_in            = S_U_N_RD;
         end

         S_U_N_RD: begin
            if (n_ff != bba_pkg::NIL) begin
               link_cmd.addr = n_ff[bba_pkg::IDX_W-1:0];
               state_in      = S_U_N_WR;
            end else begin
               x_in     = x_ff & ~sp[bba_pkg::IDX_W-1:0];
               lvl_in   = lvl_ff - 1'b1;
               state_in = S_F_MRG_RD;
            end
         end

         S_U_N_WR: begin
            link_cmd.we         = 1'b1;
            link_cmd.addr       = n_ff[bba_pkg::IDX_W-1:0];
            link_cmd.wdata.next = link_rd.next;
            link_cmd.wdata.prev = p_ff;
            x_in                = x_ff & ~sp[bba_pkg::IDX_W-1:0];
            lvl_in              = lvl_ff - 1'b1;
            state_in            = S_F_MRG_RD;
         end

         // push the block onto its level list
         S_P_START: begin
            n_in = head_rd;
            if (head_rd != bba_pkg::NIL) begin
               link_cmd.addr = head_rd[bba_pkg::IDX_W-1:0];
               state_in      = S_P_H_WR;
            end else begin
               state_in = S_P_X;
            end
         end

         S_P_H_WR: begin
            link_cmd.we         = 1'b1;
            link_cmd.addr       = n_ff[bba_pkg::IDX_W-1:0];
            link_cmd.wdata.next = link_rd.next;
            link_cmd.wdata.prev = {1'b0, x_ff};
            state_in            = S_P_X;
         end

         S_P_X: begin
            link_cmd.we         = 1'b1;
            link_cmd.addr       = x_ff;
            link_cmd.wdata.next = n_ff;
            link_cmd.wdata.prev = bba_pkg::NIL;
            head_we             = 1'b1;
            head_widx           = lvl_ff;
            head_wdata          = {1'b0, x_ff};
            gnt_in              = '0;
            fail_in             = 1'b0;
            state_in            = S_DONE;
         end

         // hand the item over once the output slot is free
         S_DONE: begin
            if (slot_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign idle                  = (state_ff == S_IDLE);
   assign result.status         = fail_ff ? bba_pkg::STATUS_FAIL : bba_pkg::STATUS_OK;
   assign result.granted_offset = bba_pkg::OFF_W'({gnt_ff, {bba_pkg::LEAF_LOG2{1'b0}}});

   // state and registered values
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         bytes_ff <= bba_pkg::BYTES_W'(bba_pkg::META_BYTES);
         fail_ff  <= 1'b0;
         for (int i = 0; i < bba_pkg::LEVELS; i++) begin
            heads_ff[i] <= bba_pkg::head_reset(bba_pkg::LVL_W'(i));
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         bytes_ff <= bytes_in;
         fail_ff  <= fail_in;
         if (head_we) begin
            heads_ff[head_widx] <= head_wdata;
         end
      end
      req_ff  <= req_in;
      x_ff    <= x_in;
      b_ff    <= b_in;
      gnt_ff  <= gnt_in;
      lvl_ff  <= lvl_in;
      j_ff    <= j_in;
      size_ff <= size_in;
      n_ff    <= n_in;
      p_ff    <= p_in;
   end

endmodule

@@ rtl/buddy_block_allocator.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a 64 KiB region with 16-byte leaves: allocate and
// free items, one result item each.
// ----------------------------------------------------------------------------
// Allocate searches the levels, pops the head and splits level by level;
//   free searches the split marks level by level, then merges buddies
//   level by level and pushes the merged block. Each read-modify-write of
//   the link or node-bit RAM uses a read state and a write state.
// One item in flight; the next item is accepted the cycle after the result
//   item is registered.
// Reset: a clearing pass sweeps every node-bit RAM entry and seeds the
//   metadata block; req_ready stays low until it ends.
// ----------------------------------------------------------------------------
module buddy_block_allocator (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bba_pkg::req_type req_item,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bba_pkg::rsp_type rsp_item
);

   logic                  idle;
   logic                  done;
   logic                  start;
   logic                  slot_free;
   bba_pkg::rsp_type      result;
   bba_pkg::link_cmd_type link_cmd;
   bba_pkg::link_type     link_rd;
   bba_pkg::bit_cmd_type  bit_cmd;
   bba_pkg::bits_type     bit_rd;
   logic                  rsp_valid_ff;
   bba_pkg::rsp_type      rsp_item_ff;

   assign req_ready = idle;
   assign start     = req_valid && req_ready;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   bba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .slot_free (slot_free),
      .idle      (idle),
      .done      (done),
      .result    (result),
      .link_cmd  (link_cmd),
      .link_rd   (link_rd),
      .bit_cmd   (bit_cmd),
      .bit_rd    (bit_rd)
   );

   // per-leaf list links
   bba_ram #(
      .WIDTH ($bits(bba_pkg::link_type)),
      .DEPTH (bba_pkg::LEAVES)
   ) u_link_ram (
      .clock (clock),
      .we    (link_cmd.we),
      .addr  (link_cmd.addr),
      .wdata (link_cmd.wdata),
      .rdata (link_rd)
   );

   // split marks and pair parity
   bba_ram #(
      .WIDTH ($bits(bba_pkg::bits_type)),
      .DEPTH (bba_pkg::LEAVES)
   ) u_bit_ram (
      .clock (clock),
      .we    (bit_cmd.we),
      .addr  (bit_cmd.addr),
      .wdata (bit_cmd.wdata),
      .rdata (bit_rd)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (done) begin
         rsp_item_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
